/* sv/ttnsg_pkg.sv */
// shared constants, types and functions of the three tone noise sound generator
package ttnsg_pkg;

    localparam int COUNT_FRACTION_BITS = 8;
    localparam int PERIOD_W = 18;
    localparam int PHASE_W  = PERIOD_W + 2 + COUNT_FRACTION_BITS + 1;
    localparam int TSTEP_W  = 20;
    localparam int NSTEP_W  = 21;
    localparam int CFG_W    = 21;
    localparam int ACC_W    = 16;
    localparam int SAMPLE_W = 15;

    localparam logic [1:0] REG_VARIANT = 2'd0;
    localparam logic [1:0] REG_EXTRA   = 2'd1;
    localparam logic [1:0] REG_TSTEP   = 2'd2;
    localparam logic [1:0] REG_NSTEP   = 2'd3;

    localparam logic [2:0] LATCH_NOISE = 3'd6;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 18'd65472;

    typedef logic signed [PHASE_W-1:0] phase_t;

    function automatic logic [15:0] fb_mask(input logic variant);
        fb_mask = variant ? 16'h8000 : 16'h4000;
    endfunction

    function automatic logic [PERIOD_W-1:0] make_period(input logic [3:0] lo,
        input logic [6:0] hi, input logic extra);
        logic [10:0] p;
        p = {hi, lo};
        if (!extra)
        begin
            p[10] = 1'b0;
        end
        if (p == 11'd0)
        begin
            p = extra ? 11'd2047 + 11'd1 : 11'd1024;
        end
        make_period = (p == 11'd0) ? 18'd131072 : {1'b0, p, 6'd0};
    endfunction

    function automatic logic [PERIOD_W-1:0] noise_period(input logic [1:0] r,
        input logic [PERIOD_W-1:0] tone1);
        case (r)
            2'd0:    noise_period = 18'h400;
            2'd1:    noise_period = 18'h800;
            2'd2:    noise_period = 18'h1000;
            default: noise_period = tone1;
        endcase
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] s,
        input logic variant, input logic white);
        logic fb;
        logic b2;
        fb = variant ? s[1] : s[0];
        b2 = variant ? ~s[5] : s[1];
        if (white)
        begin
            fb = fb ^ b2;
        end
        lfsr_next = {1'b0, s[15:1]} | (fb ? fb_mask(variant) : 16'h0000);
    endfunction

    function automatic logic [11:0] tone_amp(input logic [3:0] g);
        case (g)
            4'd0:    tone_amp = 12'd0;
            4'd1:    tone_amp = 12'd75;
            4'd2:    tone_amp = 12'd95;
            4'd3:    tone_amp = 12'd120;
            4'd4:    tone_amp = 12'd151;
            4'd5:    tone_amp = 12'd190;
            4'd6:    tone_amp = 12'd239;
            4'd7:    tone_amp = 12'd301;
            4'd8:    tone_amp = 12'd380;
            4'd9:    tone_amp = 12'd478;
            4'd10:   tone_amp = 12'd602;
            4'd11:   tone_amp = 12'd758;
            4'd12:   tone_amp = 12'd954;
            4'd13:   tone_amp = 12'd1201;
            4'd14:   tone_amp = 12'd1513;
            default: tone_amp = 12'd1905;
        endcase
    endfunction

    function automatic logic [11:0] noise_amp(input logic [3:0] g);
        case (g)
            4'd0:    noise_amp = 12'd0;
            4'd1:    noise_amp = 12'd151;
            4'd2:    noise_amp = 12'd190;
            4'd3:    noise_amp = 12'd240;
            4'd4:    noise_amp = 12'd302;
            4'd5:    noise_amp = 12'd381;
            4'd6:    noise_amp = 12'd479;
            4'd7:    noise_amp = 12'd603;
            4'd8:    noise_amp = 12'd760;
            4'd9:    noise_amp = 12'd957;
            4'd10:   noise_amp = 12'd1204;
            4'd11:   noise_amp = 12'd1516;
            4'd12:   noise_amp = 12'd1909;
            4'd13:   noise_amp = 12'd2403;
            4'd14:   noise_amp = 12'd3027;
            default: noise_amp = 12'd3810;
        endcase
    endfunction

endpackage

/* sv/ttnsg_if.sv */
// command and sample channel interfaces
interface ttnsg_cmd_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data;
    modport source (output valid, output mode, output data, input ready);
    modport sink (input valid, input mode, input data, output ready);
endinterface

interface ttnsg_smp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ttnsg_pkg::SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

/* sv/ttnsg_phase_alu.sv */
// shared phase counter add and subtract unit
module ttnsg_phase_alu (
    input  ttnsg_pkg::phase_t a,
    input  ttnsg_pkg::phase_t b,
    input  logic              sub,
    output ttnsg_pkg::phase_t y
);
    assign y = sub ? (a - b) : (a + b);
endmodule

/* sv/three_tone_noise_sound_generator.sv */
// three tone plus noise sound generator top level
// a command byte transfer gives no sample
// a tick runs one subtract step and one compare step per counter plus one add step per counter wrap,
// then an output step that waits while the previous sample is not taken
// wraps are set by step over period: up to 64 per tone and 32 for noise, one shared adder
// reset sets all registers but pc_reg and sample_reg to power-up values; no clearing pass
module three_tone_noise_sound_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    ttnsg_cmd_if.sink                      item,
    ttnsg_smp_if.source                    result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [ttnsg_pkg::CFG_W-1:0]    cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUB  = 2'd1;
    localparam logic [1:0] ST_LOOP = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int PW = ttnsg_pkg::PERIOD_W;
    localparam int XW = ttnsg_pkg::PHASE_W;
    localparam int AW = ttnsg_pkg::ACC_W;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  ch_reg, ch_next;
    logic        variant_reg, extra_reg;
    logic [ttnsg_pkg::TSTEP_W-1:0] tstep_reg;
    logic [ttnsg_pkg::NSTEP_W-1:0] nstep_reg;

    logic [PW-1:0] period_reg [4];
    ttnsg_pkg::phase_t phase_reg [4];
    logic [2:0]  pol_reg;
    logic [3:0]  gain_reg [4];
    logic [3:0]  lo_reg [4];
    logic [6:0]  hi_reg [4];
    logic [15:0] lfsr_reg;
    logic [3:0]  nctl_reg;
    logic [7:0]  latch_reg;
    logic [1:0]  last_ch_reg;

    ttnsg_pkg::phase_t pc_reg;
    logic signed [AW-1:0] acc_reg;
    logic        out_valid_reg;
    logic signed [ttnsg_pkg::SAMPLE_W-1:0] sample_reg;

    ttnsg_pkg::phase_t alu_a, alu_b, alu_y;
    logic alu_sub;

    logic cmd_xfer, tick_xfer, byte_xfer;
    logic [7:0] d;
    logic [2:0] rsel;
    logic [1:0] tone_ch, vol_ch, dch;
    logic [3:0] ng;
    logic [11:0] amp;
    logic signed [AW-1:0] contrib, acc_neg;
    logic [XW-1:0] add_val;

    assign item.ready = (state_reg == ST_IDLE);
    assign cmd_xfer   = item.valid && item.ready;
    assign tick_xfer  = cmd_xfer && item.mode;
    assign byte_xfer  = cmd_xfer && !item.mode;
    assign d          = item.data;
    assign rsel       = d[6:4];
    assign tone_ch    = 2'd3 - rsel[2:1];
    assign vol_ch     = 2'd3 - rsel[2:1];
    assign dch        = last_ch_reg;

    assign result.valid  = out_valid_reg;
    assign result.sample = sample_reg;

    // amplitude contribution and period add value of the current channel
    always_comb
    begin
        ng = gain_reg[ch_reg];
        if (ch_reg == 2'd0)
        begin
            amp     = ttnsg_pkg::noise_amp(ng);
            contrib = lfsr_reg[0] ? '0 : AW'($signed({1'b0, amp}));
        end
        else
        begin
            amp = ttnsg_pkg::tone_amp(ng);
            if (period_reg[ch_reg] > PW'(256) && pol_reg[ch_reg - 2'd1])
            begin
                contrib = -AW'($signed({1'b0, amp}));
            end
            else
            begin
                contrib = AW'($signed({1'b0, amp}));
            end
        end
        if (ch_reg == 2'd0)
        begin
            add_val = XW'(period_reg[0]) << (ttnsg_pkg::COUNT_FRACTION_BITS + 2);
        end
        else
        begin
            add_val = XW'(period_reg[ch_reg]) << ttnsg_pkg::COUNT_FRACTION_BITS;
        end
    end

    always_comb
    begin
        if (state_reg == ST_SUB)
        begin
            alu_a   = phase_reg[ch_reg];
            alu_b   = (ch_reg == 2'd0) ? XW'(nstep_reg) : XW'(tstep_reg);
            alu_sub = 1'b1;
        end
        else
        begin
            alu_a   = pc_reg;
            alu_b   = add_val;
            alu_sub = 1'b0;
        end
    end

    ttnsg_phase_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign acc_neg = variant_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_xfer)
                begin
                    state_next = ST_SUB;
                    ch_next    = 2'd1;
                end
            end
            ST_SUB:
            begin
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (!pc_reg[XW-1])
                begin
                    if (ch_reg == 2'd0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SUB;
                        ch_next    = ch_reg + 2'd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
            variant_reg   <= 1'b0;
            extra_reg     <= 1'b0;
            tstep_reg     <= 20'd76362;
            nstep_reg     <= 21'd152725;
            pol_reg       <= 3'd0;
            lfsr_reg      <= ttnsg_pkg::fb_mask(1'b0);
            nctl_reg      <= 4'd3;
            latch_reg     <= 8'd0;
            last_ch_reg   <= 2'd0;
            acc_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                period_reg[i] <= ttnsg_pkg::PERIOD_RESET;
                phase_reg[i]  <= '0;
                gain_reg[i]   <= (i == 0) ? 4'd0 : 4'd8;
                lo_reg[i]     <= 4'd0;
                hi_reg[i]     <= 7'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    ttnsg_pkg::REG_VARIANT: variant_reg <= cfg_data[0];
                    ttnsg_pkg::REG_EXTRA:   extra_reg   <= cfg_data[0];
                    ttnsg_pkg::REG_TSTEP:   tstep_reg   <= cfg_data[ttnsg_pkg::TSTEP_W-1:0];
                    ttnsg_pkg::REG_NSTEP:   nstep_reg   <= cfg_data[ttnsg_pkg::NSTEP_W-1:0];
                    default:                variant_reg <= variant_reg;
                endcase
            end

            if (result.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            if (byte_xfer)
            begin
                if (d[7])
                begin
                    latch_reg <= d;
                    if (rsel[0])
                    begin
                        gain_reg[vol_ch] <= 4'd15 - d[3:0];
                    end
                    else if (rsel == ttnsg_pkg::LATCH_NOISE)
                    begin
                        if ((d[2] != nctl_reg[2]) || !variant_reg)
                        begin
                            lfsr_reg <= ttnsg_pkg::fb_mask(variant_reg);
                        end
                        nctl_reg      <= d[3:0];
                        period_reg[0] <= ttnsg_pkg::noise_period(d[1:0], period_reg[1]);
                    end
                    else
                    begin
                        lo_reg[tone_ch]     <= d[3:0];
                        period_reg[tone_ch] <= ttnsg_pkg::make_period(d[3:0],
                            hi_reg[tone_ch], extra_reg);
                        last_ch_reg         <= tone_ch;
                    end
                end
                else if (!(variant_reg && (latch_reg[4] ||
                         latch_reg[6:4] == ttnsg_pkg::LATCH_NOISE)))
                begin
                    if (latch_reg[6:4] == ttnsg_pkg::LATCH_NOISE)
                    begin
                        lfsr_reg      <= ttnsg_pkg::fb_mask(variant_reg);
                        nctl_reg      <= d[3:0];
                        period_reg[0] <= ttnsg_pkg::noise_period(d[1:0], period_reg[1]);
                    end
                    else
                    begin
                        hi_reg[dch]     <= d[6:0];
                        period_reg[dch] <= ttnsg_pkg::make_period(lo_reg[dch], d[6:0],
                            extra_reg);
                        if (nctl_reg[1:0] == 2'd3 && dch == 2'd1)
                        begin
                            period_reg[0] <= ttnsg_pkg::make_period(lo_reg[dch], d[6:0],
                                extra_reg);
                        end
                    end
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (tick_xfer)
                    begin
                        acc_reg <= '0;
                    end
                end
                ST_SUB:
                begin
                    acc_reg <= acc_reg + contrib;
                    pc_reg  <= alu_y;
                end
                ST_LOOP:
                begin
                    if (pc_reg[XW-1])
                    begin
                        pc_reg <= alu_y;
                        if (ch_reg == 2'd0)
                        begin
                            lfsr_reg <= ttnsg_pkg::lfsr_next(lfsr_reg, variant_reg,
                                nctl_reg[2]);
                        end
                        else
                        begin
                            pol_reg[ch_reg - 2'd1] <= ~pol_reg[ch_reg - 2'd1];
                        end
                    end
                    else
                    begin
                        phase_reg[ch_reg] <= pc_reg;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        sample_reg    <= acc_neg[ttnsg_pkg::SAMPLE_W-1:0];
                    end
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

endmodule

/* verif/three_tone_noise_sound_generator_checker.sv */
// sample predictor and scoreboard for the three tone noise sound generator
`timescale 1ns / 1ps
module three_tone_noise_sound_generator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    ttnsg_cmd_if                          item,
    ttnsg_smp_if                          result,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [ttnsg_pkg::CFG_W-1:0]   cfg_data,
    output int                            fails,
    output int                            pending,
    output int                            n_ticks,
    output int                            n_cmds
);

    localparam int TONE_GAIN[16] = '{0, 75, 95, 120, 151, 190, 239, 301, 380, 478, 602, 758,
        954, 1201, 1513, 1905};
    localparam int NOISE_GAIN[16] = '{0, 151, 190, 240, 302, 381, 479, 603, 760, 957, 1204,
        1516, 1909, 2403, 3027, 3810};

    logic                           variant;
    logic                           extra;
    logic [ttnsg_pkg::TSTEP_W-1:0]  tone_inc;
    logic [ttnsg_pkg::NSTEP_W-1:0]  noise_inc;
    logic [17:0]                    per[4];
    longint                         ph[4];
    logic                           pol[3];
    logic [3:0]                     gain[4];
    logic [3:0]                     lo_nib[4];
    logic [6:0]                     hi_bits[4];
    logic [15:0]                    shift_reg;
    logic [3:0]                     noise_ctl;
    logic [7:0]                     latched;
    logic [1:0]                     tone_sel;
    logic [ttnsg_pkg::SAMPLE_W-1:0] sample_queue[$];

    function automatic logic [15:0] seed_mask();
        return variant ? 16'h8000 : 16'h4000;
    endfunction

    function automatic logic [17:0] period_of(int ch);
        int p;
        p = int'({hi_bits[ch], lo_nib[ch]});
        if (!extra)
        begin
            p = p & 'h3ff;
        end
        if (p == 0)
        begin
            p = extra ? 2048 : 1024;
        end
        return 18'(p << 6);
    endfunction

    function automatic void load_noise(logic [7:0] d);
        noise_ctl = d[3:0];
        if (d[1:0] == 2'd3)
        begin
            per[0] = per[1];
        end
        else
        begin
            per[0] = 18'h400 << d[1:0];
        end
    endfunction

    function automatic void shift_noise();
        logic fb;
        logic b2;
        fb = variant ? shift_reg[1] : shift_reg[0];
        if (noise_ctl[2])
        begin
            b2 = variant ? ~shift_reg[5] : shift_reg[1];
            fb = fb ^ b2;
        end
        shift_reg = (shift_reg >> 1) | (fb ? seed_mask() : 16'h0);
    endfunction

    function automatic void apply_byte(logic [7:0] d);
        logic [2:0] r;
        int ch;
        if (d[7])
        begin
            r = d[6:4];
            latched = d;
            ch = 3 - r[2:1];
            if (r[0])
            begin
                gain[ch] = 4'd15 - d[3:0];
            end
            else if (r == ttnsg_pkg::LATCH_NOISE)
            begin
                if (d[2] != noise_ctl[2] || !variant)
                begin
                    shift_reg = seed_mask();
                end
                load_noise(d);
            end
            else
            begin
                lo_nib[ch] = d[3:0];
                per[ch] = period_of(ch);
                tone_sel = 2'(ch);
            end
        end
        else
        begin
            r = latched[6:4];
            if (variant && (latched[4] || r == ttnsg_pkg::LATCH_NOISE))
            begin
                return;
            end
            if (r == ttnsg_pkg::LATCH_NOISE)
            begin
                shift_reg = seed_mask();
                load_noise(d);
            end
            else
            begin
                ch = tone_sel;
                hi_bits[ch] = d[6:0];
                per[ch] = period_of(ch);
                if (noise_ctl[1:0] == 2'd3 && ch == 1)
                begin
                    per[0] = per[1];
                end
            end
        end
    endfunction

    function automatic logic [ttnsg_pkg::SAMPLE_W-1:0] mix_tick();
        int acc;
        int amp;
        acc = 0;
        for (int c = 1; c < 4; c++)
        begin
            amp = TONE_GAIN[gain[c]];
            if (per[c] > 18'd256)
            begin
                acc += pol[c-1] ? -amp : amp;
            end
            else
            begin
                acc += amp;
            end
            ph[c] -= longint'(tone_inc);
            while (ph[c] < 0)
            begin
                ph[c] += longint'(per[c]) << ttnsg_pkg::COUNT_FRACTION_BITS;
                pol[c-1] = ~pol[c-1];
            end
        end
        if (!shift_reg[0])
        begin
            acc += NOISE_GAIN[gain[0]];
        end
        ph[0] -= longint'(noise_inc);
        while (ph[0] < 0)
        begin
            ph[0] += (longint'(per[0]) * 4) << ttnsg_pkg::COUNT_FRACTION_BITS;
            shift_noise();
        end
        if (variant)
        begin
            acc = -acc;
        end
        return acc[ttnsg_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic report(string what, logic [ttnsg_pkg::SAMPLE_W-1:0] got,
        logic [ttnsg_pkg::SAMPLE_W-1:0] want);
        $display("%0t mismatch: %s sample got %0d want %0d", $time, what,
            $signed(got), $signed(want));
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant = 1'b0;
            extra = 1'b0;
            tone_inc = 20'd76362;
            noise_inc = 21'd152725;
            for (int i = 0; i < 4; i++)
            begin
                per[i] = ttnsg_pkg::PERIOD_RESET;
                ph[i] = 0;
                gain[i] = 4'd8;
                lo_nib[i] = 4'd0;
                hi_bits[i] = 7'd0;
            end
            gain[0] = 4'd0;
            for (int i = 0; i < 3; i++)
            begin
                pol[i] = 1'b0;
            end
            shift_reg = 16'h4000;
            noise_ctl = 4'd3;
            latched = 8'd0;
            tone_sel = 2'd0;
            sample_queue.delete();
            fails = 0;
            n_ticks = 0;
            n_cmds = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttnsg_pkg::REG_VARIANT: variant = cfg_data[0];
                    ttnsg_pkg::REG_EXTRA:   extra = cfg_data[0];
                    ttnsg_pkg::REG_TSTEP:   tone_inc = cfg_data[ttnsg_pkg::TSTEP_W-1:0];
                    default:                noise_inc = cfg_data[ttnsg_pkg::NSTEP_W-1:0];
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (item.mode)
                begin
                    sample_queue.push_back(mix_tick());
                    n_ticks++;
                end
                else
                begin
                    apply_byte(item.data);
                    n_cmds++;
                end
            end
            if (result.valid && result.ready)
            begin
                if (sample_queue.size() == 0)
                begin
                    report("unexpected", result.sample, '0);
                end
                else if (result.sample !== sample_queue[0])
                begin
                    report("wrong", result.sample, sample_queue.pop_front());
                end
                else
                begin
                    void'(sample_queue.pop_front());
                end
            end
            pending = sample_queue.size();
        end
    end

endmodule

/* verif/three_tone_noise_sound_generator_tb.sv */
// stimulus and verdict for the three tone noise sound generator
`timescale 1ns / 1ps
module three_tone_noise_sound_generator_tb;

    localparam int LIMIT = 1000000;
    localparam int SETTLE = 300;
    localparam logic [8:0] TICK = 9'h100;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [ttnsg_pkg::CFG_W-1:0] cfg_data;
    int                          fails;
    int                          pending;
    int                          n_ticks;
    int                          n_cmds;
    int                          cycles;
    bit                          hold_req;

    ttnsg_cmd_if item ();
    ttnsg_smp_if result ();

    three_tone_noise_sound_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    three_tone_noise_sound_generator_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .n_ticks   (n_ticks),
        .n_cmds    (n_cmds)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [8:0] it);
        int g;
        bit hit;
        g = gap_len();
        if (g > 0)
        begin
            item.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.mode <= it[8];
        item.data <= it[7:0];
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = item.ready;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ttnsg_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(bit v, bit e, int unsigned ts, int unsigned ns);
        write_reg(ttnsg_pkg::REG_VARIANT, v);
        write_reg(ttnsg_pkg::REG_EXTRA, e);
        write_reg(ttnsg_pkg::REG_TSTEP, ts);
        write_reg(ttnsg_pkg::REG_NSTEP, ns);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_items(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                send({1'b1, 8'($urandom_range(0, 255))});
            end
            else if (r < 72)
            begin
                send({1'b0, 1'b1, 7'($urandom_range(0, 127))});
            end
            else
            begin
                send({1'b0, 8'($urandom_range(0, 255))});
            end
        end
    endtask

    // receiver side, with one long hold so the block backs up
    initial
    begin
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result.ready <= 1'b0;
                for (int n = 0; n < 400; n++)
                begin
                    @(posedge clk);
                end
            end
            g = gap_len();
            if (g > 0)
            begin
                result.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [8:0] directed[] = '{9'h055, TICK, 9'h08F, 9'h07F, TICK, 9'h0A0, 9'h000, TICK,
            9'h0C1, 9'h000, TICK, 9'h090, 9'h0BF, 9'h0DF, 9'h0F0, TICK, 9'h0E7, TICK,
            9'h0E4, TICK, 9'h0F0, 9'h005, 9'h0E0, 9'h006, TICK};
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item.valid = 1'b0;
        item.mode = 1'b0;
        item.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_all(1'b0, 1'b0, 76362, 152725);
        foreach (directed[i])
        begin
            send(directed[i]);
        end
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send(TICK);
        end
        random_items(70);
        drain();

        set_all(1'b1, 1'b1, 1048575, 2097151);
        random_items(100);
        drain();

        set_all(1'b0, 1'b1, 0, 0);
        random_items(60);
        drain();

        set_all(1'b1, 1'b0, $urandom_range(1000, 200000), $urandom_range(1000, 400000));
        random_items(180);
        drain();

        $display("ran %0d sample ticks and %0d command bytes over four settings",
            n_ticks, n_cmds);
        $display("settings included both variants, both period widths, zero and max steps");
        if (fails == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
